// ===== rtl/core/ogdc_pkg.sv =====
package ogdc_pkg;

  localparam int InDataW  = 56;
  localparam int InUserW  = 2;
  localparam int OutDataW = 40;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgWarn   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDanger = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStart  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgStep   = 2'd3;

  localparam logic [7:0] AsciiF = 8'd70;
  localparam logic [7:0] AsciiB = 8'd66;
  localparam logic [7:0] AsciiL = 8'd76;
  localparam logic [7:0] AsciiR = 8'd82;
  localparam logic [7:0] AsciiS = 8'd83;
  localparam logic [7:0] AsciiU = 8'd85;
  localparam logic [7:0] AsciiD = 8'd68;

  localparam logic [1:0] LevelSafe   = 2'd0;
  localparam logic [1:0] LevelWarn   = 2'd1;
  localparam logic [1:0] LevelDanger = 2'd2;

  localparam logic [1:0] DirOff = 2'd0;
  localparam logic [1:0] DirFwd = 2'd1;
  localparam logic [1:0] DirRev = 2'd2;

  localparam logic [2:0] ModeStop  = 3'd0;
  localparam logic [2:0] ModeFwd   = 3'd1;
  localparam logic [2:0] ModeBack  = 3'd2;
  localparam logic [2:0] ModeLeft  = 3'd3;
  localparam logic [2:0] ModeRight = 3'd4;

  localparam logic [6:0] SweepLow  = 7'd60;
  localparam logic [6:0] SweepHigh = 7'd120;

  typedef struct packed {
    logic capture;
    logic conv;
    logic avg;
    logic eval;
    logic drive;
  } ctrl_cmd_t;

  typedef struct packed {
    logic radar;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/core/ogdc_ctrl.sv =====
module ogdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ogdc_pkg::ctrl_sts_t sts,
  output ogdc_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {ST_IDLE, ST_CONV, ST_AVG, ST_EVAL, ST_DRIVE} state_t;

  state_t state, state_next;

  always_comb begin
    s_tready    = (state == ST_IDLE) || ((state == ST_DRIVE) && sts.out_free);
    cmd.capture = s_tvalid && s_tready;
    cmd.conv    = (state == ST_CONV);
    cmd.avg     = (state == ST_AVG);
    cmd.eval    = (state == ST_EVAL);
    cmd.drive   = (state == ST_DRIVE) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_CONV;
      end
      ST_CONV: begin
        state_next = sts.radar ? ST_AVG : ST_DRIVE;
      end
      ST_AVG: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_DRIVE;
      end
      ST_DRIVE: begin
        if (sts.out_free) state_next = cmd.capture ? ST_CONV : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/ogdc_dp.sv =====
module ogdc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ogdc_pkg::ctrl_cmd_t               cmd,
  output ogdc_pkg::ctrl_sts_t               sts,
  input  logic [ogdc_pkg::InDataW-1:0]      s_tdata,
  input  logic [ogdc_pkg::InUserW-1:0]      s_tuser,
  input  logic                              cfg_valid,
  input  logic [ogdc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ogdc_pkg::CfgDataW-1:0]     cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ogdc_pkg::OutDataW-1:0]     m_tdata
);

  typedef enum logic [2:0] {CMD_S, CMD_F, CMD_B, CMD_L, CMD_R, CMD_U, CMD_D} cmd_t;

  localparam logic [1:0] CfgWarn   = ogdc_pkg::CfgWarn;
  localparam logic [1:0] CfgDanger = ogdc_pkg::CfgDanger;
  localparam logic [1:0] CfgStart  = ogdc_pkg::CfgStart;
  localparam logic [1:0] CfgStep   = ogdc_pkg::CfgStep;

  localparam logic [7:0] AsciiF = ogdc_pkg::AsciiF;
  localparam logic [7:0] AsciiB = ogdc_pkg::AsciiB;
  localparam logic [7:0] AsciiL = ogdc_pkg::AsciiL;
  localparam logic [7:0] AsciiR = ogdc_pkg::AsciiR;
  localparam logic [7:0] AsciiS = ogdc_pkg::AsciiS;
  localparam logic [7:0] AsciiU = ogdc_pkg::AsciiU;
  localparam logic [7:0] AsciiD = ogdc_pkg::AsciiD;

  localparam logic [1:0] LevelSafe   = ogdc_pkg::LevelSafe;
  localparam logic [1:0] LevelWarn   = ogdc_pkg::LevelWarn;
  localparam logic [1:0] LevelDanger = ogdc_pkg::LevelDanger;

  // floor(x*m >> k) reciprocals, exact over the reachable input ranges
  localparam logic [18:0] CmMul    = 19'd285213;  // us*17/1000, k=24
  localparam logic [9:0]  Div3Mul  = 10'd683;     // /3, k=11
  localparam logic [8:0]  ConfMul  = 9'd410;      // 2d/5, k=10
  localparam logic [9:0]  WarnMul  = 10'd615;     // 3b/5, k=10
  localparam logic [13:0] TurnMul  = 14'd11473;   // 7d/10, k=14

  localparam logic [8:0] RangeLimit = 9'd200;
  localparam logic [7:0] SpeedMax   = 8'd255;
  localparam logic [7:0] SpeedMin   = 8'd100;
  localparam logic [6:0] SweepStep  = 7'd5;
  localparam logic [6:0] ServoReset = 7'd90;
  localparam logic [6:0] ConfFull   = 7'd100;

  localparam logic [7:0] WarnReset   = 8'd30;
  localparam logic [7:0] DangerReset = 8'd15;
  localparam logic [7:0] StartReset  = 8'd150;
  localparam logic [7:0] StepReset   = 8'd25;

  // captured beat
  logic        in_byte_valid;
  logic [7:0]  in_rx_byte;
  logic        in_radar;
  logic [13:0] echo [3];

  logic [8:0]  cm [3];
  logic [8:0]  cm_next [3];
  logic [7:0]  avg_d;
  logic        avg_none;

  logic [7:0]  warn_cm, danger_cm, speed_step;
  logic [7:0]  base_speed, derated_speed;
  cmd_t        held_cmd, last_straight;
  logic [6:0]  sweep_angle, servo_out;
  logic        sweep_rising, safety_override;
  logic [1:0]  held_level;
  logic [6:0]  held_conf;

  logic        out_valid;
  logic [ogdc_pkg::OutDataW-1:0] out_data;

  // byte decode
  logic        byte_known;
  cmd_t        byte_cmd;

  always_comb begin
    byte_known = 1'b1;
    byte_cmd   = CMD_S;
    unique case (in_rx_byte)
      AsciiF:  byte_cmd = CMD_F;
      AsciiB:  byte_cmd = CMD_B;
      AsciiL:  byte_cmd = CMD_L;
      AsciiR:  byte_cmd = CMD_R;
      AsciiS:  byte_cmd = CMD_S;
      AsciiU:  byte_cmd = CMD_U;
      AsciiD:  byte_cmd = CMD_D;
      default: byte_known = 1'b0;
    endcase
  end

  // echo to cm, three lanes
  logic [32:0] cm_prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm_prod[i] = {19'd0, echo[i]} * {14'd0, CmMul};
      cm_next[i] = cm_prod[i][32:24];
    end
  end

  // average of valid readings
  logic [9:0]  sum;
  logic [1:0]  cnt;
  logic [19:0] div3_prod;
  logic [7:0]  d_next;

  always_comb begin
    sum = 10'd0;
    cnt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if ((cm[i] != 9'd0) && (cm[i] < RangeLimit)) begin
        sum = sum + {1'b0, cm[i]};
        cnt = cnt + 2'd1;
      end
    end
    div3_prod = {10'd0, sum} * {10'd0, Div3Mul};
    case (cnt)
      2'd1:    d_next = sum[7:0];
      2'd2:    d_next = sum[8:1];
      2'd3:    d_next = div3_prod[18:11];
      default: d_next = 8'd0;
    endcase
  end

  // tick evaluation
  logic [16:0] conf_prod;
  logic [17:0] warn_prod;
  logic [6:0]  conf_next;
  logic [1:0]  level_next;
  logic [7:0]  derate_next;
  logic        ovr_next;
  logic [6:0]  sw_step, angle_next;
  logic        rising_next;

  always_comb begin
    conf_prod = {9'd0, avg_d} * {8'd0, ConfMul};
    warn_prod = {10'd0, base_speed} * {8'd0, WarnMul};
    if (avg_none) begin
      conf_next   = 7'd0;
      level_next  = LevelSafe;
      derate_next = base_speed;
      ovr_next    = 1'b0;
    end else begin
      conf_next = ConfFull - conf_prod[16:10];
      if (avg_d <= danger_cm) begin
        level_next  = LevelDanger;
        derate_next = 8'd0;
        ovr_next    = 1'b1;
      end else if (avg_d <= warn_cm) begin
        level_next  = LevelWarn;
        derate_next = warn_prod[17:10];
        ovr_next    = 1'b0;
      end else begin
        level_next  = LevelSafe;
        derate_next = base_speed;
        ovr_next    = 1'b0;
      end
    end

    if (sweep_rising) sw_step = sweep_angle + SweepStep;
    else sw_step = (sweep_angle >= SweepStep) ? sweep_angle - SweepStep : 7'd0;
    rising_next = sweep_rising;
    if (sw_step >= ogdc_pkg::SweepHigh) begin
      angle_next  = ogdc_pkg::SweepHigh;
      rising_next = 1'b0;
    end else if (sw_step <= ogdc_pkg::SweepLow) begin
      angle_next  = ogdc_pkg::SweepLow;
      rising_next = 1'b1;
    end else begin
      angle_next = sw_step;
    end
  end

  // drive decision
  logic [8:0]  up_sum, down_floor;
  logic [7:0]  base_next, derated_next;
  cmd_t        run_cmd, last_next;
  logic [21:0] turn_prod;
  logic [1:0]  dir_a, dir_b;
  logic [7:0]  pwm;
  logic [2:0]  mode;

  always_comb begin
    up_sum       = {1'b0, base_speed} + {1'b0, speed_step};
    down_floor   = {1'b0, SpeedMin} + {1'b0, speed_step};
    base_next    = base_speed;
    derated_next = derated_speed;
    run_cmd      = held_cmd;
    last_next    = last_straight;
    dir_a        = ogdc_pkg::DirOff;
    dir_b        = ogdc_pkg::DirOff;
    pwm          = 8'd0;
    mode         = ogdc_pkg::ModeStop;
    if (!safety_override) begin
      if (held_cmd == CMD_U) begin
        base_next    = up_sum[8] ? SpeedMax : up_sum[7:0];
        derated_next = base_next;
        run_cmd      = last_straight;
      end else if (held_cmd == CMD_D) begin
        base_next    = ({1'b0, base_speed} < down_floor) ? SpeedMin : base_speed - speed_step;
        derated_next = base_next;
        run_cmd      = last_straight;
      end
    end
    turn_prod = {14'd0, derated_next} * {8'd0, TurnMul};
    if (!safety_override) begin
      case (run_cmd)
        CMD_F: begin
          dir_a     = ogdc_pkg::DirFwd;
          dir_b     = ogdc_pkg::DirFwd;
          pwm       = derated_next;
          mode      = ogdc_pkg::ModeFwd;
          last_next = CMD_F;
        end
        CMD_B: begin
          dir_a     = ogdc_pkg::DirRev;
          dir_b     = ogdc_pkg::DirRev;
          pwm       = base_next;
          mode      = ogdc_pkg::ModeBack;
          last_next = CMD_B;
        end
        CMD_L: begin
          dir_a = ogdc_pkg::DirRev;
          dir_b = ogdc_pkg::DirFwd;
          pwm   = turn_prod[21:14];
          mode  = ogdc_pkg::ModeLeft;
        end
        CMD_R: begin
          dir_a = ogdc_pkg::DirFwd;
          dir_b = ogdc_pkg::DirRev;
          pwm   = turn_prod[21:14];
          mode  = ogdc_pkg::ModeRight;
        end
        CMD_S: begin
          last_next = CMD_S;
        end
        default: begin
          last_next = last_straight;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_rx_byte    <= s_tdata[7:0];
      echo[0]       <= s_tdata[21:8];
      echo[1]       <= s_tdata[35:22];
      echo[2]       <= s_tdata[49:36];
      in_byte_valid <= s_tuser[0];
      in_radar      <= s_tuser[1];
    end
    if (cmd.conv) begin
      for (int i = 0; i < 3; i++) cm[i] <= cm_next[i];
    end
    if (cmd.avg) begin
      avg_d    <= d_next;
      avg_none <= (cnt == 2'd0);
    end
    if (cmd.drive) begin
      out_data <= {safety_override, held_conf, held_level, servo_out, mode,
                   pwm, pwm, dir_b, dir_a};
    end
  end

  // controller-visible and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_cm         <= WarnReset;
      danger_cm       <= DangerReset;
      speed_step      <= StepReset;
      base_speed      <= StartReset;
      derated_speed   <= StartReset;
      held_cmd        <= CMD_S;
      last_straight   <= CMD_S;
      sweep_angle     <= ogdc_pkg::SweepLow;
      sweep_rising    <= 1'b1;
      safety_override <= 1'b0;
      servo_out       <= ServoReset;
      held_level      <= LevelSafe;
      held_conf       <= 7'd0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.conv && in_byte_valid && byte_known) held_cmd <= byte_cmd;
      if (cmd.eval) begin
        servo_out       <= sweep_angle;
        sweep_angle     <= angle_next;
        sweep_rising    <= rising_next;
        held_conf       <= conf_next;
        held_level      <= level_next;
        derated_speed   <= derate_next;
        safety_override <= ovr_next;
      end
      if (cmd.drive) begin
        base_speed    <= base_next;
        derated_speed <= derated_next;
        held_cmd      <= run_cmd;
        last_straight <= last_next;
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CfgWarn:   warn_cm <= cfg_data;
          CfgDanger: danger_cm <= cfg_data;
          CfgStart: begin
            base_speed    <= cfg_data;
            derated_speed <= cfg_data;
          end
          CfgStep:   speed_step <= cfg_data;
          default:   speed_step <= speed_step;
        endcase
      end
    end
  end

  assign sts.radar    = in_radar;
  assign sts.out_free = !out_valid || m_tready;
  assign m_tvalid     = out_valid;
  assign m_tdata      = out_data;

endmodule

// ===== rtl/core/obstacle_guarded_drive_control_unit.sv =====
// channel  | signals                          | beat content
// ---------+----------------------------------+-------------------------------------
// s        | s_tvalid s_tready s_tdata s_tuser | one loop pass: byte and radar tick
// m        | m_tvalid m_tready m_tdata         | motor, servo and safety status
// cfg      | cfg_valid cfg_ready cfg_index/data| register write, always ready
//
// A pass walks capture, echo conversion, averaging, evaluation and drive in the
// controller FSM; without a radar tick it goes from conversion straight to drive.
// The next beat is taken in the drive cycle when the output register is free.
// Reset (rst, synchronous) restores the default thresholds and speeds.
// A stalled m side holds the result; one further beat may be accepted meanwhile.
module obstacle_guarded_drive_control_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // rx_byte[7:0], echo_us_first[21:8], echo_us_second[35:22],
  // echo_us_third[49:36], zero pad[55:50]
  input  logic [ogdc_pkg::InDataW-1:0]  s_tdata,
  // byte_valid[0], radar_due[1]
  input  logic [ogdc_pkg::InUserW-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // motor_a_dir[1:0], motor_b_dir[3:2], pwm_a[11:4], pwm_b[19:12],
  // drive_mode[22:20], servo_angle[29:23], safety_level[31:30],
  // confidence[38:32], override_on[39]
  output logic [ogdc_pkg::OutDataW-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ogdc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ogdc_pkg::CfgDataW-1:0] cfg_data
);

  ogdc_pkg::ctrl_cmd_t cmd;
  ogdc_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  ogdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ogdc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== rtl/core/ogdc_chk.sv =====
module ogdc_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ogdc_pkg::OutDataW-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken during a pass");

  a_pwm_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:4] == m_tdata[19:12])
    else $error("pwm duties differ");

  a_override_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[39] |->
      m_tdata[22:20] == ogdc_pkg::ModeStop && m_tdata[11:4] == 8'd0)
    else $error("motors driven under override");

  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[29:23] >= ogdc_pkg::SweepLow &&
                 m_tdata[29:23] <= ogdc_pkg::SweepHigh)
    else $error("servo angle out of sweep range");

endmodule

bind obstacle_guarded_drive_control_unit ogdc_chk u_ogdc_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/obstacle_guarded_drive_control_unit_tb.sv =====
module obstacle_guarded_drive_control_unit_tb;

  localparam int CycleLimit = 400000;
  localparam int StallCycles = 80;
  localparam int TailCycles = 8;

  localparam logic [7:0] CmdF = ogdc_pkg::AsciiF;
  localparam logic [7:0] CmdB = ogdc_pkg::AsciiB;
  localparam logic [7:0] CmdL = ogdc_pkg::AsciiL;
  localparam logic [7:0] CmdR = ogdc_pkg::AsciiR;
  localparam logic [7:0] CmdS = ogdc_pkg::AsciiS;
  localparam logic [7:0] CmdU = ogdc_pkg::AsciiU;
  localparam logic [7:0] CmdD = ogdc_pkg::AsciiD;

  localparam logic [ogdc_pkg::CfgIdxW-1:0] RegWarn   = ogdc_pkg::CfgWarn;
  localparam logic [ogdc_pkg::CfgIdxW-1:0] RegDanger = ogdc_pkg::CfgDanger;
  localparam logic [ogdc_pkg::CfgIdxW-1:0] RegStart  = ogdc_pkg::CfgStart;
  localparam logic [ogdc_pkg::CfgIdxW-1:0] RegStep   = ogdc_pkg::CfgStep;

  localparam logic [1:0] LevelSafe   = ogdc_pkg::LevelSafe;
  localparam logic [1:0] LevelWarn   = ogdc_pkg::LevelWarn;
  localparam logic [1:0] LevelDanger = ogdc_pkg::LevelDanger;

  typedef struct packed {
    logic        radar_due;
    logic        byte_valid;
    logic [13:0] echo_c;
    logic [13:0] echo_b;
    logic [13:0] echo_a;
    logic [7:0]  rx_byte;
  } loop_pass_t;

  typedef struct packed {
    logic       override_on;
    logic [6:0] confidence;
    logic [1:0] safety_level;
    logic [6:0] servo_angle;
    logic [2:0] drive_mode;
    logic [7:0] pwm_b;
    logic [7:0] pwm_a;
    logic [1:0] motor_b_dir;
    logic [1:0] motor_a_dir;
  } drive_res_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ogdc_pkg::InDataW-1:0]  s_tdata = '0;
  logic [ogdc_pkg::InUserW-1:0]  s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ogdc_pkg::OutDataW-1:0] m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ogdc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [ogdc_pkg::CfgDataW-1:0] cfg_data = '0;

  obstacle_guarded_drive_control_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted controller state
  logic [7:0] warn_lim, danger_lim, start_spd, spd_step;
  logic [7:0] base_spd, derated_spd, held_cmd, last_dir;
  logic [6:0] sweep_pos, servo_pos, conf_hold;
  logic       sweep_up, guard_on;
  logic [1:0] level_hold;

  loop_pass_t passes_pending[$];
  drive_res_t results_due[$];

  int  tx_gap_pct = 0;
  int  rx_gap_pct = 0;
  int  stall_asked = 0;
  int  stall_served = 0;
  int  stall_left = 0;
  logic s_fire = 1'b0;
  int  cycle_count = 0;
  int  mismatches = 0;
  int  results_checked = 0;
  int  ticks_seen = 0;
  int  guard_results = 0;
  int  reg_writes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned echo_cm(logic [13:0] us);
    int unsigned v;
    v = us;
    return v * 17 / 1000;
  endfunction

  function automatic drive_res_t drive_step(loop_pass_t p);
    drive_res_t  r;
    int unsigned cm, sum, cnt, avg_cm, s;
    logic [13:0] echoes [3];
    r = '0;
    echoes[0] = p.echo_a;
    echoes[1] = p.echo_b;
    echoes[2] = p.echo_c;
    if (p.byte_valid && (p.rx_byte inside {CmdF, CmdB, CmdL, CmdR, CmdS, CmdU, CmdD}))
      held_cmd = p.rx_byte;
    if (p.radar_due) begin
      servo_pos = sweep_pos;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < 3; i++) begin
        cm = echo_cm(echoes[i]);
        if (cm > 0 && cm < 200) begin
          sum += cm;
          cnt++;
        end
      end
      if (cnt == 0) begin
        conf_hold = 7'd0;
        level_hold = LevelSafe;
        derated_spd = base_spd;
        guard_on = 1'b0;
      end else begin
        avg_cm = sum / cnt;
        conf_hold = 7'(100 - 2 * avg_cm / 5);
        if (avg_cm <= danger_lim) begin
          level_hold = LevelDanger;
          derated_spd = 8'd0;
          guard_on = 1'b1;
        end else begin
          if (avg_cm <= warn_lim) begin
            level_hold = LevelWarn;
            s = base_spd;
            derated_spd = 8'(s * 3 / 5);
          end else begin
            level_hold = LevelSafe;
            derated_spd = base_spd;
          end
          guard_on = 1'b0;
        end
      end
      if (sweep_up) sweep_pos = sweep_pos + 7'd5;
      else sweep_pos = (sweep_pos >= 7'd5) ? sweep_pos - 7'd5 : 7'd0;
      if (sweep_pos >= ogdc_pkg::SweepHigh) begin
        sweep_pos = ogdc_pkg::SweepHigh;
        sweep_up = 1'b0;
      end else if (sweep_pos <= ogdc_pkg::SweepLow) begin
        sweep_pos = ogdc_pkg::SweepLow;
        sweep_up = 1'b1;
      end
    end
    if (!guard_on) begin
      if (held_cmd == CmdU) begin
        s = base_spd + spd_step;
        base_spd = (s > 255) ? 8'd255 : 8'(s);
        derated_spd = base_spd;
        held_cmd = last_dir;
      end else if (held_cmd == CmdD) begin
        s = base_spd;
        base_spd = (s < 100 + spd_step) ? 8'd100 : 8'(s - spd_step);
        derated_spd = base_spd;
        held_cmd = last_dir;
      end
      case (held_cmd)
        CmdF: begin
          r.motor_a_dir = ogdc_pkg::DirFwd;
          r.motor_b_dir = ogdc_pkg::DirFwd;
          r.pwm_a = derated_spd;
          r.drive_mode = ogdc_pkg::ModeFwd;
          last_dir = CmdF;
        end
        CmdB: begin
          r.motor_a_dir = ogdc_pkg::DirRev;
          r.motor_b_dir = ogdc_pkg::DirRev;
          r.pwm_a = base_spd;
          r.drive_mode = ogdc_pkg::ModeBack;
          last_dir = CmdB;
        end
        CmdL: begin
          s = derated_spd;
          r.motor_a_dir = ogdc_pkg::DirRev;
          r.motor_b_dir = ogdc_pkg::DirFwd;
          r.pwm_a = 8'(s * 7 / 10);
          r.drive_mode = ogdc_pkg::ModeLeft;
        end
        CmdR: begin
          s = derated_spd;
          r.motor_a_dir = ogdc_pkg::DirFwd;
          r.motor_b_dir = ogdc_pkg::DirRev;
          r.pwm_a = 8'(s * 7 / 10);
          r.drive_mode = ogdc_pkg::ModeRight;
        end
        CmdS: last_dir = CmdS;
        default: ;
      endcase
      r.pwm_b = r.pwm_a;
    end
    r.servo_angle = servo_pos;
    r.safety_level = level_hold;
    r.confidence = conf_hold;
    r.override_on = guard_on;
    return r;
  endfunction

  function automatic string field_diff(drive_res_t e, drive_res_t g);
    string s;
    s = "";
    if (e.motor_a_dir !== g.motor_a_dir)
      s = {s, $sformatf(" motor_a_dir exp %0d got %0d", e.motor_a_dir, g.motor_a_dir)};
    if (e.motor_b_dir !== g.motor_b_dir)
      s = {s, $sformatf(" motor_b_dir exp %0d got %0d", e.motor_b_dir, g.motor_b_dir)};
    if (e.pwm_a !== g.pwm_a)
      s = {s, $sformatf(" pwm_a exp %0d got %0d", e.pwm_a, g.pwm_a)};
    if (e.pwm_b !== g.pwm_b)
      s = {s, $sformatf(" pwm_b exp %0d got %0d", e.pwm_b, g.pwm_b)};
    if (e.drive_mode !== g.drive_mode)
      s = {s, $sformatf(" drive_mode exp %0d got %0d", e.drive_mode, g.drive_mode)};
    if (e.servo_angle !== g.servo_angle)
      s = {s, $sformatf(" servo_angle exp %0d got %0d", e.servo_angle, g.servo_angle)};
    if (e.safety_level !== g.safety_level)
      s = {s, $sformatf(" safety_level exp %0d got %0d", e.safety_level, g.safety_level)};
    if (e.confidence !== g.confidence)
      s = {s, $sformatf(" confidence exp %0d got %0d", e.confidence, g.confidence)};
    if (e.override_on !== g.override_on)
      s = {s, $sformatf(" override_on exp %0d got %0d", e.override_on, g.override_on)};
    return s;
  endfunction

  function automatic logic [13:0] random_echo();
    case ($urandom_range(0, 9))
      0: return 14'd0;
      1: return 14'($urandom_range(1, 58));
      2, 3, 4, 5: return 14'($urandom_range(59, 3000));
      6, 7: return 14'($urandom_range(59, 11764));
      8: return 14'($urandom_range(11765, 16383));
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic loop_pass_t random_pass();
    loop_pass_t p;
    p.byte_valid = ($urandom_range(0, 99) < 60);
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 6))
        0: p.rx_byte = CmdF;
        1: p.rx_byte = CmdB;
        2: p.rx_byte = CmdL;
        3: p.rx_byte = CmdR;
        4: p.rx_byte = CmdS;
        5: p.rx_byte = CmdU;
        default: p.rx_byte = CmdD;
      endcase
    end else begin
      p.rx_byte = 8'($urandom_range(0, 255));
    end
    p.radar_due = 1'($urandom_range(0, 1));
    p.echo_a = random_echo();
    p.echo_b = random_echo();
    p.echo_c = random_echo();
    return p;
  endfunction

  task automatic add_pass(logic bv, logic [7:0] rx, logic rd,
                          logic [13:0] ea, logic [13:0] eb, logic [13:0] ec);
    loop_pass_t p;
    p.byte_valid = bv;
    p.rx_byte = rx;
    p.radar_due = rd;
    p.echo_a = ea;
    p.echo_b = eb;
    p.echo_c = ec;
    passes_pending.push_back(p);
  endtask

  task automatic write_reg(logic [ogdc_pkg::CfgIdxW-1:0] idx,
                           logic [ogdc_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(int w, int d, int st, int sp);
    write_reg(RegWarn, 8'(w));
    write_reg(RegDanger, 8'(d));
    write_reg(RegStep, 8'(sp));
    write_reg(RegStart, 8'(st));
  endtask

  task automatic drain();
    while (passes_pending.size() != 0 || s_tvalid || results_due.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // sender: hold the beat until taken, then maybe gap
  always @(negedge clk) begin
    loop_pass_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (passes_pending.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
        p = passes_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, p.echo_c, p.echo_b, p.echo_a, p.rx_byte};
        s_tuser <= {p.radar_due, p.byte_valid};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus long holds on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_asked != stall_served) begin
      m_tready <= 1'b0;
      stall_left <= StallCycles;
      stall_served <= stall_served + 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_gap_pct);
    end
  end

  always @(posedge clk) begin : check_results
    drive_res_t got, want;
    loop_pass_t p;
    string      diffs;
    if (rst) begin
      s_fire <= 1'b0;
    end else begin
      s_fire <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = drive_res_t'(m_tdata);
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result %h with nothing expected", $time, m_tdata);
        end else begin
          want = results_due.pop_front();
          diffs = field_diff(want, got);
          if (diffs != "") begin
            mismatches++;
            $display("%0t: result mismatch:%s", $time, diffs);
          end
          results_checked++;
          if (got.override_on) guard_results++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          RegWarn: warn_lim = cfg_data;
          RegDanger: danger_lim = cfg_data;
          RegStart: begin
            start_spd = cfg_data;
            base_spd = cfg_data;
            derated_spd = cfg_data;
          end
          RegStep: spd_step = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        p.rx_byte = s_tdata[7:0];
        p.echo_a = s_tdata[21:8];
        p.echo_b = s_tdata[35:22];
        p.echo_c = s_tdata[49:36];
        p.byte_valid = s_tuser[0];
        p.radar_due = s_tuser[1];
        if (p.radar_due) ticks_seen++;
        results_due.push_back(drive_step(p));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d results still due", $time, results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    warn_lim = 8'd30;
    danger_lim = 8'd15;
    start_spd = 8'd150;
    spd_step = 8'd25;
    base_spd = start_spd;
    derated_spd = start_spd;
    held_cmd = CmdS;
    last_dir = CmdS;
    sweep_pos = ogdc_pkg::SweepLow;
    sweep_up = 1'b1;
    guard_on = 1'b0;
    servo_pos = 7'd90;
    level_hold = LevelSafe;
    conf_hold = 7'd0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_gap_pct = 34;
    rx_gap_pct = 53;
    add_pass(0, 8'd0, 0, 0, 0, 0);
    add_pass(1, CmdF, 0, 0, 0, 0);
    add_pass(0, CmdB, 0, 0, 0, 0);
    add_pass(1, CmdB, 0, 0, 0, 0);
    add_pass(1, CmdL, 0, 0, 0, 0);
    add_pass(1, CmdR, 0, 0, 0, 0);
    add_pass(1, 8'h58, 0, 0, 0, 0);
    add_pass(1, 8'hFF, 0, 0, 0, 0);
    add_pass(1, CmdU, 0, 0, 0, 0);
    add_pass(1, CmdD, 0, 0, 0, 0);
    add_pass(0, 8'd0, 1, 0, 0, 0);
    add_pass(1, CmdF, 1, 500, 500, 500);        // byte with danger tick
    add_pass(1, CmdU, 0, 0, 0, 0);              // held while override on
    add_pass(0, 8'd0, 1, 1765, 1765, 1765);     // warn edge, clears override
    add_pass(0, 8'd0, 1, 883, 883, 883);        // danger edge
    add_pass(1, CmdS, 1, 942, 942, 942);
    add_pass(0, 8'd0, 1, 15000, 58, 1000);
    add_pass(0, 8'd0, 1, 16383, 16383, 16383);
    add_pass(1, CmdL, 1, 11764, 11764, 59);
    add_pass(1, CmdD, 1, 11765, 3000, 6000);
    add_pass(1, CmdB, 0, 0, 0, 0);
    add_pass(1, CmdD, 0, 0, 0, 0);
    add_pass(1, 8'h00, 1, 59, 59, 59);
    add_pass(1, CmdR, 1, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_regs(30, 15, 150, 25);
        1: load_regs(199, 199, 255, 155);
        2: load_regs(0, 0, 100, 1);
        3: load_regs(40, 60, 200, 50);
        default: load_regs($urandom_range(0, 199), $urandom_range(0, 199),
                           $urandom_range(100, 255), $urandom_range(1, 155));
      endcase
      if (ph < 2) begin
        tx_gap_pct = 34;
        rx_gap_pct = 53;
      end else if (ph < 4) begin
        tx_gap_pct = 53;
        rx_gap_pct = 34;
      end else begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end
      for (int i = 0; i < (ph == 5 ? 230 : 240); i++)
        passes_pending.push_back(random_pass());
      if (ph == 0 || ph == 3 || ph == 4) stall_asked = stall_asked + 1;
      drain();
    end

    $display("Checked %0d results from %0d radar ticks and %0d register writes,",
             results_checked, ticks_seen, reg_writes);
    $display("%0d results under obstacle override, %0d mismatches.",
             guard_results, mismatches);
    if (mismatches == 0 && results_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ogdc_pkg.sv
rtl/core/ogdc_ctrl.sv
rtl/core/ogdc_dp.sv
rtl/core/obstacle_guarded_drive_control_unit.sv
rtl/core/ogdc_chk.sv
dv/obstacle_guarded_drive_control_unit_tb.sv
